### rtl/core/rtp_playout_jitter_buffer_assert.svh
// ---------------------------------------------------------------------------
// rtp playout jitter buffer assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ---------------------------------------------------------------------------
`ifndef RTP_PLAYOUT_JITTER_BUFFER_ASSERT_SVH
`define RTP_PLAYOUT_JITTER_BUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RJB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RJB_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
    else $error(msg);
`else
`define RJB_ASSERT(label, prop, msg)
`define RJB_ASSERT_NEXT(label, cond, nxt, msg)
`endif
`endif

### rtl/core/rjb_pkg.sv
// ---------------------------------------------------------------------------
// rjb_pkg
// shared types, codes and constants of the rtp playout jitter buffer
// ---------------------------------------------------------------------------
package rjb_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TAG_BITS    = 16;
    localparam int DIV_BITS        = 64;

    localparam logic [30:0] CLOCK_RATE_RST = 31'd90000;
    localparam logic [6:0]  MAX_ITEMS_RST  = 7'd64;
    localparam logic [31:0] MAX_BYTES_RST  = 32'hFFFF_FFFF;
    localparam logic [6:0]  STARTUP_RST    = 7'd1;

    localparam logic [29:0] NS_PER_S = 30'd1000000000;
    localparam logic [63:0] Q_LIMIT  = 64'd9223372036;
    localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POLL  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    localparam logic [3:0] ST_QUEUED    = 4'd0;
    localparam logic [3:0] ST_NO_DATA   = 4'd1;
    localparam logic [3:0] ST_TIMELINE  = 4'd2;
    localparam logic [3:0] ST_NON_MONO  = 4'd3;
    localparam logic [3:0] ST_ITEM_FULL = 4'd4;
    localparam logic [3:0] ST_BYTE_FULL = 4'd5;
    localparam logic [3:0] ST_LATE      = 4'd6;
    localparam logic [3:0] ST_RELEASED  = 4'd7;
    localparam logic [3:0] ST_NOT_READY = 4'd8;
    localparam logic [3:0] ST_FLUSHED   = 4'd9;

    localparam logic [1:0] CFG_CLOCK_RATE = 2'd0;
    localparam logic [1:0] CFG_MAX_ITEMS  = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES  = 2'd2;
    localparam logic [1:0] CFG_STARTUP    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] au_tag;
        logic [31:0] payload_bytes;
        logic [31:0] rtp_timestamp;
        logic [62:0] now_ns;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] released_tag;
        logic        next_valid;
        logic [62:0] next_ready_ns;
        logic [6:0]  held_count;
        logic [31:0] held_bytes;
        logic        playing;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_UNW, S_NEG, S_DIV1, S_MULR, S_MULQ, S_DIV2, S_SUM, S_MED,
        S_CHK, S_REL1, S_REL2, S_PCK, S_WR, S_PCHK, S_RD, S_RDL, S_FIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {RET_PUSH, RET_POLL, RET_FIN} t_ret;

endpackage

### rtl/core/rjb_div.sv
// ---------------------------------------------------------------------------
// rjb_div
// bit-serial restoring divider, 64-bit dividend by 31-bit divisor
// ---------------------------------------------------------------------------
module rjb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [30:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient,
    output logic [30:0] o_remainder
);
    import rjb_pkg::*;

    localparam int NW = $clog2(DIV_BITS + 1);

    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [63:0]   r_q;
    logic [30:0]   r_r;
    logic [30:0]   r_d;
    logic [31:0]   trial;
    logic [31:0]   diff;
    logic          ge;

    assign trial = {r_r, r_q[63]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_r <= ge ? diff[30:0] : trial[30:0];
            r_q <= {r_q[62:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

endmodule

### rtl/core/rjb_store.sv
// ---------------------------------------------------------------------------
// rjb_store
// entry memory: one write port, one registered read port
// ---------------------------------------------------------------------------
module rjb_store #(
    parameter int DEPTH = rjb_pkg::DEF_QUEUE_DEPTH,
    parameter int TW    = rjb_pkg::DEF_TAG_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [63:0]              i_wmedia,
    input  logic [31:0]              i_wbytes,
    input  logic [TW-1:0]            i_wtag,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [63:0]              o_rmedia,
    output logic [31:0]              o_rbytes,
    output logic [TW-1:0]            o_rtag
);
    logic [63:0]   mem_media [DEPTH];
    logic [31:0]   mem_bytes [DEPTH];
    logic [TW-1:0] mem_tag   [DEPTH];
    logic [63:0]   r_media;
    logic [31:0]   r_bytes;
    logic [TW-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_media[i_waddr] <= i_wmedia;
            mem_bytes[i_waddr] <= i_wbytes;
            mem_tag[i_waddr]   <= i_wtag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_media <= mem_media[i_raddr];
            r_bytes <= mem_bytes[i_raddr];
            r_tag   <= mem_tag[i_raddr];
        end
    end

    assign o_rmedia = r_media;
    assign o_rbytes = r_bytes;
    assign o_rtag   = r_tag;

endmodule

### rtl/core/rtp_playout_jitter_buffer.sv
// ---------------------------------------------------------------------------
// rtp_playout_jitter_buffer
// fixed-delay rtp playout fifo with timestamp unwrap and ns conversion
//
//   channel   valid         stall         payload
//   input     i_in_valid    o_in_stall    i_in  (t_in_item)
//   output    o_out_valid   i_out_stall   o_out (t_out_item)
//   config    i_cfg_we      -             i_cfg_addr / i_cfg_wdata
//
// a push that reaches the divider runs the bit-serial divider twice;
// a poll, a flush and a push refused before the divide do not use it,
// and every beat ends in the output state, held there while output stall is up
// one beat is in flight at a time; the result holds until taken
// reset is synchronous, active low; the entry memory needs no clearing
// ---------------------------------------------------------------------------
`include "rtp_playout_jitter_buffer_assert.svh"

module rtp_playout_jitter_buffer #(
    parameter int QUEUE_DEPTH = rjb_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = rjb_pkg::DEF_TAG_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rjb_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rjb_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata
);
    import rjb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = (CW > 7) ? CW : 7;
    localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;

    t_state        r_state, n_state;
    t_ret          r_ret;
    t_in_item      r_in;
    logic [3:0]    r_status;
    logic [TW-1:0] r_rtag;

    logic [30:0]   r_clock_rate;
    logic [6:0]    r_max_items;
    logic [31:0]   r_max_bytes;
    logic [6:0]    r_startup;

    logic [PW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [31:0]   r_retained;
    logic          r_started;
    logic [63:0]   r_first_media, r_first_ready;
    logic          r_seen;
    logic [31:0]   r_last_raw;
    logic [63:0]   r_last_ticks;

    logic [63:0]   r_ticks;
    logic          r_neg;
    logic [63:0]   r_q1;
    logic [30:0]   r_rem1;
    logic [63:0]   r_prod, r_hi;
    logic [29:0]   r_lo;
    logic [64:0]   r_sum;
    logic          r_err;
    logic [63:0]   r_media, r_tl_media;
    logic [63:0]   r_hd_media;
    logic [31:0]   r_hd_bytes;
    logic [TW-1:0] r_hd_tag;
    logic [63:0]   r_rarg, r_off, r_rel;
    logic          r_ovf;
    logic [32:0]   r_bsum;

    logic          in_acc;
    logic          div_start, div_done;
    logic [63:0]   div_dividend, div_quo;
    logic [30:0]   div_rem;
    logic [33:0]   mul_a;
    logic [63:0]   mul_p;
    logic          mem_we, mem_re;
    logic [63:0]   rd_media;
    logic [31:0]   rd_bytes;
    logic [TW-1:0] rd_tag;
    logic [31:0]   raw_delta;
    logic [63:0]   t_ext, mag;
    logic [63:0]   off_d, rel_d, rel_sat;
    logic          sub_ovf, add_ovf;
    logic          chk3, chk4, chk5, release_ok, play_go;
    logic [63:0]   now64;
    logic [PW-1:0] head_inc, tail_inc;

    assign in_acc = i_in_valid && !o_in_stall;
    assign now64  = {1'b0, r_in.now_ns};

    // timestamp unwrap and magnitude
    assign raw_delta = r_in.rtp_timestamp - r_last_raw;
    assign t_ext     = r_seen ? (r_last_ticks + {{32{raw_delta[31]}}, raw_delta})
                              : {32'b0, r_in.rtp_timestamp};
    assign mag       = r_ticks[63] ? (~r_ticks + 64'd1) : r_ticks;

    // shared multiplier
    assign mul_a = (r_state == S_MULR) ? 34'(r_rem1) : r_q1[33:0];
    assign mul_p = {30'd0, mul_a} * {34'd0, NS_PER_S};

    // release time of r_rarg
    assign off_d   = r_rarg - r_first_media;
    assign sub_ovf = (r_rarg[63] != r_first_media[63]) && (off_d[63] != r_rarg[63]);
    assign rel_d   = r_first_ready + r_off;
    assign add_ovf = (r_first_ready[63] == r_off[63]) && (rel_d[63] != r_first_ready[63]);
    assign rel_sat = r_ovf ? S64_MAX : (r_rel[63] ? 64'd0 : r_rel);

    assign chk3 = (r_count != '0) && ($signed(r_media) < $signed(r_tl_media));
    assign chk4 = (MW'(r_count) >= MW'(r_max_items)) || (r_count >= CW'(QUEUE_DEPTH));
    assign chk5 = r_bsum > {1'b0, r_max_bytes};
    assign release_ok = now64 >= rel_sat;
    assign play_go    = !r_started && ((MW'(r_count) + MW'(1)) >= MW'(r_startup));

    assign head_inc = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    rjb_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_clock_rate),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rjb_store #(.DEPTH(QUEUE_DEPTH), .TW(TW)) u_store (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (r_tail),
        .i_wmedia (r_media),
        .i_wbytes (r_in.payload_bytes),
        .i_wtag   (r_in.au_tag[TW-1:0]),
        .i_re     (mem_re),
        .i_raddr  (r_head),
        .o_rmedia (rd_media),
        .o_rbytes (rd_bytes),
        .o_rtag   (rd_tag)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        KIND_PUSH:  n_state = S_UNW;
                        KIND_POLL:  n_state = (r_count != '0 && r_started) ? S_REL1 : S_FIN;
                        KIND_FLUSH: n_state = S_OUT;
                        default:    n_state = S_FIN;
                    endcase
                end
            end
            S_UNW: begin
                if (r_in.payload_bytes == '0 || r_clock_rate == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_NEG;
                end
            end
            S_NEG:  n_state = S_DIV1;
            S_DIV1: n_state = div_done ? S_MULR : S_DIV1;
            S_MULR: n_state = S_MULQ;
            S_MULQ: n_state = S_DIV2;
            S_DIV2: n_state = div_done ? S_SUM : S_DIV2;
            S_SUM:  n_state = S_MED;
            S_MED:  n_state = (r_err || r_sum > {1'b0, S64_MAX}) ? S_FIN : S_CHK;
            S_CHK: begin
                if (chk3 || chk4 || chk5) begin
                    n_state = S_FIN;
                end else begin
                    n_state = r_started ? S_REL1 : S_WR;
                end
            end
            S_REL1: n_state = S_REL2;
            S_REL2: begin
                case (r_ret)
                    RET_PUSH: n_state = S_PCK;
                    RET_POLL: n_state = S_PCHK;
                    default:  n_state = S_OUT;
                endcase
            end
            S_PCK: begin
                n_state = (r_ovf || $signed(r_rel) < $signed(now64)) ? S_FIN : S_WR;
            end
            S_WR:   n_state = S_FIN;
            S_PCHK: n_state = (release_ok && r_count > CW'(1)) ? S_RD : S_FIN;
            S_RD:   n_state = S_RDL;
            S_RDL:  n_state = S_FIN;
            S_FIN:  n_state = (r_started && r_count != '0) ? S_REL1 : S_OUT;
            S_OUT:  n_state = i_out_stall ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        div_start    = (r_state == S_NEG) || (r_state == S_MULQ);
        div_dividend = (r_state == S_NEG) ? mag : r_prod;
        mem_we       = (r_state == S_WR);
        mem_re       = (r_state == S_RD);
        o_in_stall   = (r_state != S_IDLE);
        o_out_valid  = (r_state == S_OUT);
        o_out.status        = r_status;
        o_out.released_tag  = 16'(r_rtag);
        o_out.next_valid    = r_started && (r_count != '0);
        o_out.next_ready_ns = (r_started && r_count != '0) ? rel_sat[62:0] : '0;
        o_out.held_count    = 7'(r_count);
        o_out.held_bytes    = r_retained;
        o_out.playing       = r_started;
    end

    // control and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ret         <= RET_FIN;
            r_clock_rate  <= CLOCK_RATE_RST;
            r_max_items   <= MAX_ITEMS_RST;
            r_max_bytes   <= MAX_BYTES_RST;
            r_startup     <= STARTUP_RST;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_retained    <= '0;
            r_started     <= 1'b0;
            r_first_media <= '0;
            r_first_ready <= '0;
            r_seen        <= 1'b0;
            r_last_raw    <= '0;
            r_last_ticks  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CLOCK_RATE: r_clock_rate <= i_cfg_wdata[30:0];
                    CFG_MAX_ITEMS:  r_max_items  <= i_cfg_wdata[6:0];
                    CFG_MAX_BYTES:  r_max_bytes  <= i_cfg_wdata;
                    CFG_STARTUP:    r_startup    <= i_cfg_wdata[6:0];
                    default:        r_startup    <= r_startup;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_ret <= RET_POLL;
                    if (in_acc && i_in.kind == KIND_FLUSH) begin
                        r_head        <= '0;
                        r_tail        <= '0;
                        r_count       <= '0;
                        r_retained    <= '0;
                        r_started     <= 1'b0;
                        r_first_media <= '0;
                        r_first_ready <= '0;
                        r_seen        <= 1'b0;
                        r_last_raw    <= '0;
                        r_last_ticks  <= '0;
                    end
                end
                S_UNW: begin
                    if (r_in.payload_bytes != '0 && r_clock_rate != '0) begin
                        r_seen       <= 1'b1;
                        r_last_raw   <= r_in.rtp_timestamp;
                        r_last_ticks <= t_ext;
                    end
                end
                S_CHK: r_ret <= RET_PUSH;
                S_WR: begin
                    r_tail     <= tail_inc;
                    r_count    <= r_count + 1'b1;
                    r_retained <= r_bsum[31:0];
                    if (play_go) begin
                        r_started     <= 1'b1;
                        r_first_media <= (r_count == '0) ? r_media : r_hd_media;
                        r_first_ready <= now64;
                    end
                end
                S_PCHK: begin
                    if (release_ok) begin
                        r_retained <= r_retained - r_hd_bytes;
                        r_head     <= head_inc;
                        r_count    <= r_count - 1'b1;
                    end
                end
                S_FIN:   r_ret <= RET_FIN;
                default: r_ret <= r_ret;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_in     <= i_in;
                    r_rtag   <= '0;
                    r_status <= (i_in.kind == KIND_FLUSH) ? ST_FLUSHED : ST_NOT_READY;
                    r_rarg   <= r_hd_media;
                end
            end
            S_UNW: begin
                r_ticks <= t_ext;
                if (r_in.payload_bytes == '0) begin
                    r_status <= ST_NO_DATA;
                end else if (r_clock_rate == '0) begin
                    r_status <= ST_TIMELINE;
                end
            end
            S_NEG: r_neg <= r_ticks[63];
            S_DIV1: begin
                r_q1   <= div_quo;
                r_rem1 <= div_rem;
            end
            S_MULR: r_prod <= mul_p;
            S_MULQ: r_hi   <= mul_p;
            S_DIV2: r_lo   <= div_quo[29:0];
            S_SUM: begin
                r_sum <= {1'b0, r_hi} + 65'(r_lo);
                r_err <= r_q1 > Q_LIMIT;
            end
            S_MED: begin
                r_media <= r_neg ? (~r_sum[63:0] + 64'd1) : r_sum[63:0];
                r_bsum  <= {1'b0, r_retained} + {1'b0, r_in.payload_bytes};
                if (r_err || r_sum > {1'b0, S64_MAX}) begin
                    r_status <= ST_TIMELINE;
                end
            end
            S_CHK: begin
                r_rarg <= r_media;
                if (chk3) begin
                    r_status <= ST_NON_MONO;
                end else if (chk4) begin
                    r_status <= ST_ITEM_FULL;
                end else if (chk5) begin
                    r_status <= ST_BYTE_FULL;
                end
            end
            S_REL1: begin
                r_off <= off_d;
                r_ovf <= sub_ovf;
            end
            S_REL2: begin
                r_rel <= rel_d;
                r_ovf <= r_ovf || add_ovf;
            end
            S_PCK: begin
                if (r_ovf) begin
                    r_status <= ST_TIMELINE;
                end else if ($signed(r_rel) < $signed(now64)) begin
                    r_status <= ST_LATE;
                end
            end
            S_WR: begin
                r_status   <= ST_QUEUED;
                r_tl_media <= r_media;
                if (r_count == '0) begin
                    r_hd_media <= r_media;
                    r_hd_bytes <= r_in.payload_bytes;
                    r_hd_tag   <= r_in.au_tag[TW-1:0];
                end
            end
            S_PCHK: begin
                if (release_ok) begin
                    r_status <= ST_RELEASED;
                    r_rtag   <= r_hd_tag;
                end
            end
            S_RDL: begin
                r_hd_media <= rd_media;
                r_hd_bytes <= rd_bytes;
                r_hd_tag   <= rd_tag;
            end
            S_FIN:   r_rarg <= r_hd_media;
            default: r_rarg <= r_rarg;
        endcase
    end

    `RJB_ASSERT(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "held count beyond queue depth")
    `RJB_ASSERT(a_empty_no_bytes, (r_count == '0) |-> (r_retained == '0), "bytes held on empty queue")
    `RJB_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE, "accepted beat not taken up")

endmodule
